FILE: hdl/biv_pkg.sv
// ============================================================================
// biv_pkg : shared types and constants of the b-value integrator
// Holds the fixed datapath widths and the accumulator control struct.
// ============================================================================
package biv_pkg;

  // Fixed field and datapath widths.
  localparam int MOM_W   = 48;   // running moment, two's complement
  localparam int B_W     = 64;   // running b-value, unsigned
  localparam int SHIFT_W = 6;    // b_shift register
  localparam int ACC_W   = 128;  // shift-accumulate register
  localparam int MUL_A_W = 33;   // shared multiplier, first operand
  localparam int MUL_B_W = 32;   // shared multiplier, second operand
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int HALF_W  = MOM_W / 2;  // limb width used to square the moment
  localparam int S_W     = 96;   // sum of the two squares, three 32-bit limbs

  localparam logic [SHIFT_W-1:0] B_SHIFT_RST = 6'd32;

  // Alignment of a product when it is added into the accumulator.
  typedef logic [2:0] acc_sh_t;
  localparam acc_sh_t SH_0  = 3'd0;
  localparam acc_sh_t SH_25 = 3'd1;
  localparam acc_sh_t SH_32 = 3'd2;
  localparam acc_sh_t SH_48 = 3'd3;
  localparam acc_sh_t SH_64 = 3'd4;

  typedef struct packed {
    logic    clr;   // clear the accumulator
    logic    add;   // add the aligned product
    acc_sh_t sh;    // alignment of the product
  } acc_ctl_t;

endpackage

FILE: hdl/biv_mul.sv
// ============================================================================
// biv_mul : shared registered multiplier
// Unsigned 33 x 32 bit product, registered once.
// ============================================================================
module biv_mul (
  input  logic                          clk,
  input  logic [biv_pkg::MUL_A_W-1:0]   a,
  input  logic [biv_pkg::MUL_B_W-1:0]   b,
  output logic [biv_pkg::PROD_W-1:0]    prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= biv_pkg::PROD_W'(a) * biv_pkg::PROD_W'(b);
  end

endmodule

FILE: hdl/biv_acc.sv
// ============================================================================
// biv_acc : 128-bit shift-accumulate unit
// Adds a registered product at one of a few fixed alignments, or clears.
// ============================================================================
module biv_acc (
  input  logic                         clk,
  input  biv_pkg::acc_ctl_t            ctl,
  input  logic [biv_pkg::PROD_W-1:0]   prod,
  output logic [biv_pkg::ACC_W-1:0]    acc_r
);

  logic [biv_pkg::ACC_W-1:0] prod_ext;
  logic [biv_pkg::ACC_W-1:0] aligned;

  assign prod_ext = biv_pkg::ACC_W'(prod);

  always_comb begin
    case (ctl.sh)
      biv_pkg::SH_0:  aligned = prod_ext;
      biv_pkg::SH_25: aligned = prod_ext << 25;
      biv_pkg::SH_32: aligned = prod_ext << 32;
      biv_pkg::SH_48: aligned = prod_ext << 48;
      biv_pkg::SH_64: aligned = prod_ext << 64;
      default:        aligned = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.add) begin
      acc_r <= acc_r + aligned;
    end
  end

endmodule

FILE: hdl/diffusion_b_value_integrator.sv
// ============================================================================
// diffusion_b_value_integrator : trapezoidal moment and b-value integrator
// Sequencer around one shared multiplier and one shift-accumulate unit.
// ============================================================================
// Sequence: a step that opens a sequence goes from idle straight to the final
//   state; every other step first runs the moment update, squares, dt product,
//   scaling and b-value add. One request is taken at a time; the ten products
//   of a step all pass through the single shared multiplier.
// Reset (rst_n, synchronous, active low) clears the running state, empties
//   the output register and sets b_shift to 32; no clearing pass is needed.
module diffusion_b_value_integrator #(
  parameter int DT_WIDTH   = 16,
  parameter int GRAD_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [biv_pkg::SHIFT_W-1:0]        cfg_wr_data,
  // input requests
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [DT_WIDTH-1:0]                in_dt_step,
  input  logic signed [GRAD_WIDTH-1:0]       in_gradient,
  input  logic                               in_last,
  // result requests
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [biv_pkg::MOM_W-1:0]   out_moment,
  output logic [biv_pkg::B_W-1:0]            out_b_value,
  output logic                               out_done_res
);

  localparam int GSUM_W = GRAD_WIDTH + 1;
  localparam int KSUM_W = biv_pkg::MOM_W + 2;

  // Sequencer states. The moment update comes first, then the two squares
  // of the moment are built from 24-bit limbs, then the sum of squares is
  // multiplied by dt one 32-bit limb at a time, and finally the product is
  // scaled and added to the b-value.
  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_KMUL  = 5'd1;
  localparam logic [4:0] ST_KUPD  = 5'd2;
  localparam logic [4:0] ST_SQ0   = 5'd3;
  localparam logic [4:0] ST_SQ1   = 5'd4;
  localparam logic [4:0] ST_SQ2   = 5'd5;
  localparam logic [4:0] ST_SQ3   = 5'd6;
  localparam logic [4:0] ST_SQ4   = 5'd7;
  localparam logic [4:0] ST_SQ5   = 5'd8;
  localparam logic [4:0] ST_SQEND = 5'd9;
  localparam logic [4:0] ST_T0    = 5'd10;
  localparam logic [4:0] ST_T1    = 5'd11;
  localparam logic [4:0] ST_T2    = 5'd12;
  localparam logic [4:0] ST_TEND  = 5'd13;
  localparam logic [4:0] ST_SHIFT = 5'd14;
  localparam logic [4:0] ST_BADD  = 5'd15;
  localparam logic [4:0] ST_FIN   = 5'd16;

  localparam logic [63:0] HALF_CLIP = 64'h0001_0000_0000_0000;

  // Control state.
  logic [4:0]                      state_r;
  logic [biv_pkg::SHIFT_W-1:0]     b_shift_r;
  logic                            first_r;
  logic                            out_valid_r;

  // Running state of the sequence.
  logic signed [GRAD_WIDTH-1:0]    prev_grad_r;
  logic signed [biv_pkg::MOM_W-1:0] moment_acc_r;
  logic [biv_pkg::B_W-1:0]         b_acc_r;

  // Working registers of the current request.
  logic [DT_WIDTH-1:0]             dt_r;
  logic signed [GRAD_WIDTH-1:0]    grad_r;
  logic                            last_r;
  logic signed [biv_pkg::MOM_W-1:0] k_new_r;
  logic [biv_pkg::MOM_W-1:0]       mag_new_r;
  logic [biv_pkg::MOM_W-1:0]       mag_old_r;
  logic [biv_pkg::S_W-1:0]         s_r;
  logic [biv_pkg::B_W-1:0]         inc_r;
  logic [biv_pkg::B_W-1:0]         b_new_r;

  // Output register.
  logic signed [biv_pkg::MOM_W-1:0] out_moment_r;
  logic [biv_pkg::B_W-1:0]         out_b_value_r;
  logic                            out_done_r;

  // Shared units.
  logic [biv_pkg::MUL_A_W-1:0]     mul_a;
  logic [biv_pkg::MUL_B_W-1:0]     mul_b;
  logic [biv_pkg::PROD_W-1:0]      prod_r;
  biv_pkg::acc_ctl_t               acc_ctl;
  logic [biv_pkg::ACC_W-1:0]       acc_r;

  // Combinational helpers.
  logic                            accept;
  logic                            out_free;
  logic [GSUM_W-1:0]               gsum;
  logic                            gsum_neg;
  logic [GSUM_W-1:0]               gmag;
  logic [63:0]                     half_raw;
  logic [48:0]                     half_c;
  logic [KSUM_W-1:0]               delta;
  logic [KSUM_W-1:0]               ksum;
  logic [biv_pkg::MOM_W-1:0]       k_sat;
  logic [biv_pkg::MOM_W-1:0]       k_sat_mag;
  logic [biv_pkg::MOM_W-1:0]       k_old_mag;
  logic [6:0]                      sh_amt;
  logic [biv_pkg::ACC_W-1:0]       t_shifted;
  logic [biv_pkg::B_W:0]           b_sum;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // Trapezoid of the gradient: the sum of this and the previous gradient,
  // carried as sign and magnitude into the unsigned multiplier.
  assign gsum     = {grad_r[GRAD_WIDTH-1], grad_r} + {prev_grad_r[GRAD_WIDTH-1], prev_grad_r};
  assign gsum_neg = gsum[GSUM_W-1];
  assign gmag     = gsum_neg ? (GSUM_W'(0) - gsum) : gsum;

  // Halving must round toward minus infinity, so a negative odd product
  // rounds its magnitude up. The step is clipped so that the sum below
  // cannot wrap before it is saturated.
  always_comb begin
    half_raw = prod_r[64:1] + 64'(gsum_neg & prod_r[0]);
    half_c   = (half_raw > HALF_CLIP) ? HALF_CLIP[48:0] : half_raw[48:0];
    delta    = gsum_neg ? (KSUM_W'(0) - {1'b0, half_c}) : {1'b0, half_c};
    ksum     = {{2{moment_acc_r[biv_pkg::MOM_W-1]}}, moment_acc_r} + delta;
    if (ksum[KSUM_W-1] && (ksum[KSUM_W-2:biv_pkg::MOM_W-1] != 2'b11)) begin
      k_sat = {1'b1, {(biv_pkg::MOM_W-1){1'b0}}};
    end else if (!ksum[KSUM_W-1] && (ksum[KSUM_W-2:biv_pkg::MOM_W-1] != 2'b00)) begin
      k_sat = {1'b0, {(biv_pkg::MOM_W-1){1'b1}}};
    end else begin
      k_sat = ksum[biv_pkg::MOM_W-1:0];
    end
    k_sat_mag = k_sat[biv_pkg::MOM_W-1] ? (biv_pkg::MOM_W'(0) - k_sat) : k_sat;
    k_old_mag = moment_acc_r[biv_pkg::MOM_W-1] ?
                (biv_pkg::MOM_W'(0) - moment_acc_r) : moment_acc_r;
  end

  // Scaling of the b increment: the /2 of the trapezoid and b_shift together,
  // then saturation of anything that does not fit in 64 bits.
  assign sh_amt    = 7'(b_shift_r) + 7'd1;
  assign t_shifted = acc_r >> sh_amt;
  assign b_sum     = {1'b0, b_acc_r} + {1'b0, inc_r};

  // Operand selection for the shared multiplier. Each multiplying state issues
  // one product; the moment update or the accumulator takes it in the next cycle.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_KMUL: begin
        mul_a = biv_pkg::MUL_A_W'(gmag);
        mul_b = biv_pkg::MUL_B_W'(dt_r);
      end
      ST_SQ0: begin
        mul_a = biv_pkg::MUL_A_W'(mag_new_r[biv_pkg::MOM_W-1:biv_pkg::HALF_W]);
        mul_b = biv_pkg::MUL_B_W'(mag_new_r[biv_pkg::MOM_W-1:biv_pkg::HALF_W]);
      end
      ST_SQ1: begin
        mul_a = biv_pkg::MUL_A_W'(mag_new_r[biv_pkg::MOM_W-1:biv_pkg::HALF_W]);
        mul_b = biv_pkg::MUL_B_W'(mag_new_r[biv_pkg::HALF_W-1:0]);
      end
      ST_SQ2: begin
        mul_a = biv_pkg::MUL_A_W'(mag_new_r[biv_pkg::HALF_W-1:0]);
        mul_b = biv_pkg::MUL_B_W'(mag_new_r[biv_pkg::HALF_W-1:0]);
      end
      ST_SQ3: begin
        mul_a = biv_pkg::MUL_A_W'(mag_old_r[biv_pkg::MOM_W-1:biv_pkg::HALF_W]);
        mul_b = biv_pkg::MUL_B_W'(mag_old_r[biv_pkg::MOM_W-1:biv_pkg::HALF_W]);
      end
      ST_SQ4: begin
        mul_a = biv_pkg::MUL_A_W'(mag_old_r[biv_pkg::MOM_W-1:biv_pkg::HALF_W]);
        mul_b = biv_pkg::MUL_B_W'(mag_old_r[biv_pkg::HALF_W-1:0]);
      end
      ST_SQ5: begin
        mul_a = biv_pkg::MUL_A_W'(mag_old_r[biv_pkg::HALF_W-1:0]);
        mul_b = biv_pkg::MUL_B_W'(mag_old_r[biv_pkg::HALF_W-1:0]);
      end
      ST_T0: begin
        mul_a = biv_pkg::MUL_A_W'(acc_r[31:0]);
        mul_b = biv_pkg::MUL_B_W'(dt_r);
      end
      ST_T1: begin
        mul_a = biv_pkg::MUL_A_W'(s_r[63:32]);
        mul_b = biv_pkg::MUL_B_W'(dt_r);
      end
      ST_T2: begin
        mul_a = biv_pkg::MUL_A_W'(s_r[95:64]);
        mul_b = biv_pkg::MUL_B_W'(dt_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Accumulator control. A square (h*2^24 + l)^2 is h*h at 48, 2*h*l at 25
  // and l*l at 0; the sum of squares times dt is built from 32-bit limbs.
  always_comb begin
    acc_ctl = '{clr: 1'b0, add: 1'b0, sh: biv_pkg::SH_0};
    case (state_r)
      ST_KUPD:  acc_ctl = '{clr: 1'b1, add: 1'b0, sh: biv_pkg::SH_0};
      ST_SQ1:   acc_ctl = '{clr: 1'b0, add: 1'b1, sh: biv_pkg::SH_48};
      ST_SQ2:   acc_ctl = '{clr: 1'b0, add: 1'b1, sh: biv_pkg::SH_25};
      ST_SQ3:   acc_ctl = '{clr: 1'b0, add: 1'b1, sh: biv_pkg::SH_0};
      ST_SQ4:   acc_ctl = '{clr: 1'b0, add: 1'b1, sh: biv_pkg::SH_48};
      ST_SQ5:   acc_ctl = '{clr: 1'b0, add: 1'b1, sh: biv_pkg::SH_25};
      ST_SQEND: acc_ctl = '{clr: 1'b0, add: 1'b1, sh: biv_pkg::SH_0};
      ST_T0:    acc_ctl = '{clr: 1'b1, add: 1'b0, sh: biv_pkg::SH_0};
      ST_T1:    acc_ctl = '{clr: 1'b0, add: 1'b1, sh: biv_pkg::SH_0};
      ST_T2:    acc_ctl = '{clr: 1'b0, add: 1'b1, sh: biv_pkg::SH_32};
      ST_TEND:  acc_ctl = '{clr: 1'b0, add: 1'b1, sh: biv_pkg::SH_64};
      default:  acc_ctl = '{clr: 1'b0, add: 1'b0, sh: biv_pkg::SH_0};
    endcase
  end

  biv_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  biv_acc u_acc (
    .clk   (clk),
    .ctl   (acc_ctl),
    .prod  (prod_r),
    .acc_r (acc_r)
  );

  // Sequencer and running state. The running state is committed only when
  // the result enters the output register, so a stalled output holds the
  // sequencer in its final state and nothing is lost.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      b_shift_r    <= biv_pkg::B_SHIFT_RST;
      first_r      <= 1'b1;
      out_valid_r  <= 1'b0;
      prev_grad_r  <= '0;
      moment_acc_r <= '0;
      b_acc_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        b_shift_r <= cfg_wr_data;
      end
      // A taken result empties the output register unless a new one
      // enters it at the same edge.
      if (out_ready && !((state_r == ST_FIN) && out_free)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= first_r ? ST_FIN : ST_KMUL;
          end
        end
        ST_KMUL:  state_r <= ST_KUPD;
        ST_KUPD:  state_r <= ST_SQ0;
        ST_SQ0:   state_r <= ST_SQ1;
        ST_SQ1:   state_r <= ST_SQ2;
        ST_SQ2:   state_r <= ST_SQ3;
        ST_SQ3:   state_r <= ST_SQ4;
        ST_SQ4:   state_r <= ST_SQ5;
        ST_SQ5:   state_r <= ST_SQEND;
        ST_SQEND: state_r <= ST_T0;
        ST_T0:    state_r <= ST_T1;
        ST_T1:    state_r <= ST_T2;
        ST_T2:    state_r <= ST_TEND;
        ST_TEND:  state_r <= ST_SHIFT;
        ST_SHIFT: state_r <= ST_BADD;
        ST_BADD:  state_r <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            // The last step of a sequence returns the running state to its
            // reset value; the register b_shift is kept.
            if (last_r) begin
              first_r      <= 1'b1;
              prev_grad_r  <= '0;
              moment_acc_r <= '0;
              b_acc_r      <= '0;
            end else begin
              first_r      <= 1'b0;
              prev_grad_r  <= grad_r;
              moment_acc_r <= k_new_r;
              b_acc_r      <= b_new_r;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Working and output registers; none of them needs a reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      dt_r    <= in_dt_step;
      grad_r  <= in_gradient;
      last_r  <= in_last;
      // The first step of a sequence only records its gradient.
      k_new_r <= moment_acc_r;
      b_new_r <= b_acc_r;
    end
    if (state_r == ST_KUPD) begin
      k_new_r   <= k_sat;
      mag_new_r <= k_sat_mag;
      mag_old_r <= k_old_mag;
    end
    if (state_r == ST_T0) begin
      s_r <= acc_r[biv_pkg::S_W-1:0];
    end
    if (state_r == ST_SHIFT) begin
      inc_r <= (|t_shifted[biv_pkg::ACC_W-1:biv_pkg::B_W]) ? '1 : t_shifted[biv_pkg::B_W-1:0];
    end
    if (state_r == ST_BADD) begin
      b_new_r <= b_sum[biv_pkg::B_W] ? '1 : b_sum[biv_pkg::B_W-1:0];
    end
    if ((state_r == ST_FIN) && out_free) begin
      out_moment_r  <= k_new_r;
      out_b_value_r <= b_new_r;
      out_done_r    <= last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_moment   = out_moment_r;
  assign out_b_value  = out_b_value_r;
  assign out_done_res = out_done_r;

endmodule

FILE: hdl/biv_chk.sv
// ============================================================================
// biv_chk : port checker of the b-value integrator
// Watches the request channels of the top level over time.
// ============================================================================
module biv_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [biv_pkg::MOM_W-1:0]  out_moment,
  input logic [biv_pkg::B_W-1:0]           out_b_value,
  input logic                              out_done_res
);

  // A result request that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_moment) && $stable(out_b_value) && $stable(out_done_res))
    else $error("result payload changed while stalled");

  // The block works on one request at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a request is in work");

  // A result never appears straight after an accepted request.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result shown in the cycle after acceptance");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind diffusion_b_value_integrator biv_chk u_biv_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_moment   (out_moment),
  .out_b_value  (out_b_value),
  .out_done_res (out_done_res)
);
